// ===== src/r2p_pkg.sv =====
// r2p_pkg: shared types and constants for the reactivity-to-probability block
// no dependencies
package r2p_pkg;
	typedef struct packed {
		logic signed [23:0] reactivity;
		logic               last_item;
	} in_beat_t;

	typedef struct packed {
		logic signed [23:0] converted_value;
		logic [5:0]         position;
		logic               last_result;
	} out_beat_t;

	localparam logic [2:0] MODE_PASS  = 3'd0;
	localparam logic [2:0] MODE_PIECE = 3'd1;
	localparam logic [2:0] MODE_CUT   = 3'd2;
	localparam logic [2:0] MODE_LIN   = 3'd3;
	localparam logic [2:0] MODE_LOG   = 3'd4;

	localparam logic [2:0] REG_MODE      = 3'd0;
	localparam logic [2:0] REG_CUTOFF    = 3'd1;
	localparam logic [2:0] REG_SLOPE     = 3'd2;
	localparam logic [2:0] REG_INTERCEPT = 3'd3;
	localparam logic [2:0] REG_DEFAULT   = 3'd4;

	localparam logic [16:0] ONE_Q16 = 17'd65536;
	localparam logic [31:0] LN2_Q32 = 32'd2977044472;
endpackage

// ===== src/r2p_div.sv =====
// r2p_div: restoring divider, one quotient bit per cycle
// depends on nothing
module r2p_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [47:0] dividend,
	input  logic [23:0] divisor,
	output logic        done,
	output logic [47:0] quotient
);
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [24:0] rem_q;
	logic [47:0] quo_q;
	logic [24:0] trial;
	logic [24:0] sub;

	assign trial = {rem_q[23:0], quo_q[47]};
	assign sub   = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd47) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			if (!sub[24]) begin
				rem_q <= sub;
				quo_q <= {quo_q[46:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[46:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
endmodule

// ===== src/reactivity_to_probability.sv =====
// reactivity_to_probability: top level, profile store, sequencer, log unit
// depends on r2p_pkg and r2p_div
//
//  channel  | direction | payload    | handshake
//  in       | in        | in_beat_t  | in_valid / in_stall
//  out      | out       | out_beat_t | out_valid / out_stall
//  cfg      | in        | 24 bits    | cfg_we, cfg_index
//
// loading stores each accepted beat; after the last beat the block stops
// taking input and emits the stored profile, one result per entry
// an entry with no divide goes through read, decide and output; a divide
// adds the start and wait states, linear first passes ST_LOGMUL, and log
// first runs 20 squaring steps, then ST_LOGN and ST_LOGMUL for the scaling
// the shared divider sets the rate; output stalls slow it further
// reset clears state, counters, peak, out_valid and configuration; the
// datapath and store hold no reset value; the store is only read where written
// a stalled result holds in the output register until taken
module reactivity_to_probability #(
	parameter int MAX_LENGTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  r2p_pkg::in_beat_t in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output r2p_pkg::out_beat_t out_data,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [23:0]       cfg_data
);
	import r2p_pkg::*;

	localparam int AW = $clog2(MAX_LENGTH);
	localparam int CW = $clog2(MAX_LENGTH + 1);

	typedef enum logic [3:0] {
		ST_LOAD, ST_READ, ST_DECIDE, ST_LOGN, ST_LOGSQ, ST_LOGMUL,
		ST_DIVGO, ST_DIVWAIT, ST_OUT
	} state_t;

	state_t state_q;

	// configuration registers
	logic [2:0]         mode_q;
	logic [22:0]        cutoff_q;
	logic [22:0]        slope_q;
	logic signed [23:0] icpt_q;
	logic signed [23:0] dflt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_PASS;
			cutoff_q <= 23'd16384;
			slope_q  <= 23'd44564;
			icpt_q   <= 24'sd13107;
			dflt_q   <= 24'sd32768;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:      mode_q   <= cfg_data[2:0];
				REG_CUTOFF:    cutoff_q <= cfg_data[22:0];
				REG_SLOPE:     slope_q  <= cfg_data[22:0];
				REG_INTERCEPT: icpt_q   <= cfg_data;
				REG_DEFAULT:   dflt_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// profile store
	logic signed [23:0] mem [MAX_LENGTH];
	logic signed [23:0] rd_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      idx_q;
	logic signed [23:0] max_q;

	logic in_acc;
	assign in_stall = (state_q != ST_LOAD);
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk) begin
		if (in_acc)
			mem[cnt_q[AW-1:0]] <= in_data.reactivity;
		rd_q <= mem[idx_q[AW-1:0]];
	end

	// datapath registers
	logic signed [47:0] num_q;     // value handed to linear map
	logic [23:0]        dvsr_q;
	logic [47:0]        dvd_q;
	logic signed [25:0] tlo_q;
	logic               neg_q;     // sign of the log result
	logic               pw_q;      // piecewise: add tlo; linear: clamp
	logic signed [23:0] res_q;
	logic [4:0]         k_q;
	logic [4:0]         step_q;
	logic [31:0]        m_q;
	logic [19:0]        frac_q;
	logic [63:0]        prod_s1;

	logic        div_start;
	logic        div_done;
	logic [47:0] div_quo;

	r2p_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dvd_q),
		.divisor  (dvsr_q),
		.done     (div_done),
		.quotient (div_quo)
	);
	assign div_start = (state_q == ST_DIVGO);

	// leading one position of the positive value
	logic [4:0] lead;
	always_comb begin
		lead = '0;
		for (int i = 0; i < 24; i++)
			if (rd_q[i]) lead = 5'(i);
	end

	// piecewise segment selection
	logic signed [24:0] v25;
	logic signed [24:0] pw_lo, pw_bp;
	logic signed [25:0] pw_tlo, pw_t;
	logic               pw_hit;
	always_comb begin
		v25    = 25'(rd_q);
		pw_hit = 1'b1;
		pw_lo  = '0; pw_bp = 25'sd16384; pw_tlo = '0; pw_t = 26'sd22938;
		if (v25 > 25'sd0 && v25 <= 25'sd16384) begin
		end else if (v25 > 25'sd16384 && v25 <= 25'sd19661) begin
			pw_lo = 25'sd16384; pw_bp = 25'sd19661; pw_tlo = 26'sd22938; pw_t = 26'sd36045;
		end else if (v25 > 25'sd19661 && v25 <= 25'sd45875) begin
			pw_lo = 25'sd19661; pw_bp = 25'sd45875; pw_tlo = 26'sd36045; pw_t = 26'sd55706;
		end else if (v25 > 25'sd45875 && v25 <= 25'(max_q)) begin
			pw_lo = 25'sd45875; pw_bp = 25'(max_q); pw_tlo = 26'sd55706; pw_t = 26'sd65536;
		end else
			pw_hit = 1'b0;
	end

	// linear numerator from num_q
	logic signed [48:0] lin_num;
	assign lin_num = 49'(num_q) - 49'(icpt_q);

	// squaring step
	logic [63:0] sq;
	logic [33:0] sq_sh;
	assign sq    = 64'(m_q) * 64'(m_q);
	assign sq_sh = sq[63:30];

	// log2 in Q20, magnitude and sign
	logic signed [25:0] l2;
	logic [25:0]        l2_mag;
	assign l2     = {6'(k_q) - 6'd16, frac_q};
	assign l2_mag = l2[25] ? 26'(-l2) : 26'(l2);

	logic [47:0] div_sat;
	assign div_sat = div_quo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			cnt_q     <= '0;
			idx_q     <= '0;
			max_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						logic signed [23:0] sub;
						sub = in_data.reactivity[23] ? dflt_q : in_data.reactivity;
						if (cnt_q == '0 || sub > max_q) max_q <= sub;
						cnt_q <= cnt_q + 1'b1;
						if (in_data.last_item || (cnt_q + 1'b1) == CW'(MAX_LENGTH)) begin
							idx_q   <= '0;
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: state_q <= ST_DECIDE; // store read latency
				ST_DECIDE: begin
					neg_q <= 1'b0;
					if (mode_q == MODE_PASS) begin
						res_q <= rd_q; state_q <= ST_OUT;
					end else if (rd_q[23]) begin
						res_q <= dflt_q; state_q <= ST_OUT;
					end else begin
						case (mode_q)
							MODE_PIECE: begin
								if (!pw_hit) begin
									res_q <= rd_q; state_q <= ST_OUT;
								end else begin
									pw_q    <= 1'b1;
									tlo_q   <= pw_tlo;
									dvd_q   <= 48'(v25 - pw_lo) * 48'(pw_t - pw_tlo);
									dvsr_q  <= 24'(pw_bp - pw_lo);
									state_q <= ST_DIVGO;
								end
							end
							MODE_CUT: begin
								res_q   <= ({1'b0, rd_q} < {2'b0, cutoff_q}) ? '0 : 24'(ONE_Q16);
								state_q <= ST_OUT;
							end
							MODE_LIN: begin
								pw_q    <= 1'b0;
								num_q   <= 48'(rd_q);
								state_q <= ST_LOGMUL; // reuse entry into linear map
								step_q  <= 5'd31;
							end
							MODE_LOG: begin
								if (rd_q == '0) begin
									res_q <= '0; state_q <= ST_OUT;
								end else begin
									pw_q    <= 1'b0;
									k_q     <= lead;
									m_q     <= 32'({8'b0, rd_q} << (5'd30 - lead));
									frac_q  <= '0;
									step_q  <= '0;
									state_q <= ST_LOGSQ;
								end
							end
							default: begin
								res_q <= rd_q; state_q <= ST_OUT;
							end
						endcase
					end
				end
				ST_LOGSQ: begin
					if (sq_sh[31]) begin
						m_q    <= sq_sh[32:1];
						frac_q <= {frac_q[18:0], 1'b1};
					end else begin
						m_q    <= sq_sh[31:0];
						frac_q <= {frac_q[18:0], 1'b0};
					end
					step_q <= step_q + 5'd1;
					if (step_q == 5'd19) state_q <= ST_LOGN;
				end
				ST_LOGN: begin
					prod_s1 <= 64'(l2_mag) * 64'(LN2_Q32);
					neg_q   <= l2[25];
					step_q  <= '0;
					state_q <= ST_LOGMUL;
				end
				ST_LOGMUL: begin
					// step 31 marks linear mode entering with num_q ready
					if (step_q != 5'd31) begin
						logic [27:0] r;
						r = 28'((prod_s1 + 64'h8_0000_0000) >> 36);
						num_q <= neg_q ? -48'(r) : 48'(r);
						step_q <= 5'd31;
					end else begin
						if (slope_q == '0) begin
							res_q <= (lin_num > 0) ? 24'(ONE_Q16) : '0;
							state_q <= ST_OUT;
						end else if (lin_num <= 0) begin
							res_q <= '0; state_q <= ST_OUT;
						end else begin
							dvd_q   <= 48'(lin_num) << 16;
							dvsr_q  <= {1'b0, slope_q};
							state_q <= ST_DIVGO;
						end
					end
				end
				ST_DIVGO: state_q <= ST_DIVWAIT;
				ST_DIVWAIT: begin
					if (div_done) begin
						if (pw_q)
							res_q <= 24'(div_sat + 48'(tlo_q));
						else
							res_q <= (div_sat > 48'(ONE_Q16)) ? 24'(ONE_Q16) : 24'(div_sat);
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_valid || !out_stall) begin
						out_valid <= 1'b1;
						out_data.converted_value <= res_q;
						out_data.position        <= 6'(idx_q);
						out_data.last_result     <= (idx_q + 1'b1) == cnt_q;
						if ((idx_q + 1'b1) == cnt_q) begin
							cnt_q   <= '0;
							max_q   <= '0;
							state_q <= ST_LOAD;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_READ;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
			if (out_valid && !out_stall && state_q != ST_OUT)
				out_valid <= 1'b0;
		end
	end
endmodule

// ===== verif/reactivity_to_probability_tb.sv =====
// reactivity_to_probability_tb: self-checking testbench for the reactivity-to-probability block
// depends on r2p_pkg and the reactivity_to_probability top level
`timescale 1ns / 1ps

module reactivity_to_probability_tb;
	import r2p_pkg::*;

	// codes the package leaves unnamed: undefined modes and unused register slots
	localparam logic [2:0] MODE_UNDEF_LO = 3'd5;
	localparam logic [2:0] MODE_UNDEF_HI = 3'd7;
	localparam logic [2:0] REG_UNUSED_LO = 3'd5;
	localparam logic [2:0] REG_UNUSED_HI = 3'd7;
	localparam int         PROFILE_MAX   = 64;
	localparam int         SETTLE_CYCLES = 80;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_beat_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_beat_t out_data;
	logic      cfg_we;
	logic [2:0] cfg_index;
	logic [23:0] cfg_data;

	reactivity_to_probability #(.MAX_LENGTH(PROFILE_MAX)) uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// shadow copy of the configuration registers
	logic [2:0]         mode_q;
	logic [22:0]        cutoff_q;
	logic [22:0]        slope_q;
	logic signed [23:0] intercept_q;
	logic signed [23:0] default_q;

	// shadow copy of the profile being loaded
	logic signed [23:0] profile_mem [PROFILE_MAX];
	int                 load_count;
	logic signed [23:0] peak_q;

	in_beat_t  pending_beats[$];
	out_beat_t expected_results[$];
	int        errors;
	bit        in_took;
	int        send_gap;
	bit        no_idle;
	int        hold_requests;
	int        hold_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("*** FAILED ***");
		$finish;
	end

	// natural log of a positive q16 value by repeated squaring, q16 result
	function automatic longint ln_q16(longint unsigned x);
		int k;
		int i;
		longint unsigned m;
		longint unsigned frac;
		longint unsigned mag;
		longint unsigned r;
		longint l2;
		k = 0;
		frac = 0;
		while (k < 31 && (x >> (k + 1)) != 0)
			k++;
		m = x << (30 - k);
		for (i = 0; i < 20; i++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m >= (64'd1 << 31)) begin
				m = m >> 1;
				frac = frac | 64'd1;
			end
		end
		l2 = longint'(k - 16) * longint'(1 << 20) + longint'(frac);
		mag = (l2 < 0) ? longint'(-l2) : longint'(l2);
		r = (mag * longint'(LN2_Q32) + (64'd1 << 35)) >> 36;
		return (l2 < 0) ? -longint'(r) : longint'(r);
	endfunction

	// (v - intercept) / slope clamped to 0..1
	function automatic longint linear_map(longint v);
		longint num;
		longint q;
		num = v - longint'(intercept_q);
		if (slope_q == 0)
			return (num > 0) ? longint'(ONE_Q16) : 0;
		if (num <= 0)
			return 0;
		q = (num * 65536) / longint'(slope_q);
		return (q > 65536) ? 65536 : q;
	endfunction

	// three fixed breakpoints plus the profile peak
	function automatic longint piecewise_map(longint v);
		longint bp[4];
		longint tg[4];
		longint lo;
		longint tlo;
		bp[0] = 16384; bp[1] = 19661; bp[2] = 45875; bp[3] = longint'(peak_q);
		tg[0] = 22938; tg[1] = 36045; tg[2] = 55706; tg[3] = 65536;
		lo = 0;
		tlo = 0;
		if (v == 0)
			return 0;
		for (int j = 0; j < 4; j++) begin
			if (v > lo && v <= bp[j])
				return (v - lo) * (tg[j] - tlo) / (bp[j] - lo) + tlo;
			lo = bp[j];
			tlo = tg[j];
		end
		return v;
	endfunction

	function automatic longint to_probability(logic signed [23:0] raw);
		longint v;
		v = longint'(raw);
		if (mode_q == MODE_PASS)
			return v;
		if (raw < 0)
			return longint'(default_q);
		case (mode_q)
			MODE_PIECE: return piecewise_map(v);
			MODE_CUT:   return (v < longint'(cutoff_q)) ? 0 : 65536;
			MODE_LIN:   return linear_map(v);
			MODE_LOG:   return (raw == 0) ? 0 : linear_map(ln_q16(longint'(raw)));
			default:    return v;
		endcase
	endfunction

	// take one accepted input beat; a closed profile queues its results
	task automatic absorb_beat(in_beat_t b);
		logic signed [23:0] sub;
		out_beat_t r;
		longint conv;
		sub = (b.reactivity < 0) ? default_q : b.reactivity;
		profile_mem[load_count] = b.reactivity;
		if (load_count == 0 || sub > peak_q)
			peak_q = sub;
		load_count++;
		if (b.last_item || load_count >= PROFILE_MAX) begin
			for (int k = 0; k < load_count; k++) begin
				conv = to_probability(profile_mem[k]);
				r.converted_value = conv[23:0];
				r.position = k[5:0];
				r.last_result = (k + 1 == load_count);
				expected_results.push_back(r);
			end
			load_count = 0;
			peak_q = '0;
		end
	endtask

	task automatic write_reg(logic [2:0] idx, logic [23:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_MODE:      mode_q = val[2:0];
			REG_CUTOFF:    cutoff_q = val[22:0];
			REG_SLOPE:     slope_q = val[22:0];
			REG_INTERCEPT: intercept_q = val;
			REG_DEFAULT:   default_q = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_all(logic [2:0] m, logic [22:0] cut, logic [22:0] slp,
			logic [23:0] icpt, logic [23:0] dflt);
		write_reg(REG_MODE, {21'd0, m});
		write_reg(REG_CUTOFF, {1'b0, cut});
		write_reg(REG_SLOPE, {1'b0, slp});
		write_reg(REG_INTERCEPT, icpt);
		write_reg(REG_DEFAULT, dflt);
	endtask

	// wait until every queued beat is in and every result is out, then let it settle
	task automatic drain();
		while (pending_beats.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic push_beat(logic [23:0] v, logic last);
		in_beat_t b;
		b.reactivity = v;
		b.last_item = last;
		pending_beats.push_back(b);
	endtask

	// reactivity with weight on missing, zero and the interesting q16 band
	function automatic logic [23:0] pick_reactivity();
		case ($urandom_range(0, 9))
			0:       return 24'($urandom());
			1:       return {1'b1, 23'($urandom())};
			2:       return 24'd0;
			3:       return 24'($urandom_range(16000, 20000));
			4:       return 24'($urandom_range(40000, 70000));
			default: return 24'($urandom_range(1, 140000));
		endcase
	endfunction

	// profiles of random length ending with the marker; last phase item always closes
	task automatic queue_profiles(int items);
		int len;
		while (items > 0) begin
			len = ($urandom_range(0, 19) == 0) ? PROFILE_MAX : $urandom_range(1, 8);
			if (len > items)
				len = items;
			for (int i = 0; i < len; i++)
				push_beat(pick_reactivity(), (i == len - 1) ? 1'b1 : ($urandom_range(0, 29) == 0));
			items -= len;
		end
	endtask

	function automatic logic [22:0] pick_level();
		return ($urandom_range(0, 3) == 0) ? 23'($urandom()) : 23'($urandom_range(0, 140000));
	endfunction

	// sampling side: predict on accepted inputs, check accepted results
	always @(posedge clk) begin
		out_beat_t want;
		in_took = 1'b0;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				absorb_beat(in_data);
				in_took = 1'b1;
			end
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result beat %h", $time, out_data);
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (out_data.converted_value !== want.converted_value) begin
						$display("%0t: converted_value expected %h got %h", $time,
							want.converted_value, out_data.converted_value);
						errors++;
					end
					if (out_data.position !== want.position) begin
						$display("%0t: position expected %0d got %0d", $time,
							want.position, out_data.position);
						errors++;
					end
					if (out_data.last_result !== want.last_result) begin
						$display("%0t: last_result expected %b got %b", $time,
							want.last_result, out_data.last_result);
						errors++;
					end
				end
			end
		end
	end

	// input driver: payload holds while stalled, gaps between beats
	always @(negedge clk) begin
		int r;
		bit nv;
		nv = in_valid;
		if (arst_n && (!in_valid || in_took)) begin
			nv = 1'b0;
			if (send_gap > 0) begin
				send_gap--;
			end else if (pending_beats.size() != 0) begin
				in_data <= pending_beats.pop_front();
				nv = 1'b1;
				r = $urandom_range(0, 99);
				if ($urandom_range(0, 63) == 0)
					no_idle = ~no_idle;
				if (no_idle || r < 60)
					send_gap = 0;
				else if (r < 92)
					send_gap = $urandom_range(1, 3);
				else
					send_gap = $urandom_range(8, 40);
			end
		end
		in_valid <= nv;
	end

	// result receiver: random stalls plus the occasional long hold-off
	always @(negedge clk) begin
		int r;
		bit ns;
		if (hold_requests > 0 && hold_left == 0) begin
			hold_requests--;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			ns = 1'b1;
		end else if (no_idle) begin
			ns = 1'b0;
		end else begin
			r = $urandom_range(0, 99);
			ns = (r < 25) || (r > 97 && $urandom_range(0, 1) == 1);
		end
		out_stall <= ns;
	end

	initial begin
		errors = 0;
		in_took = 1'b0;
		send_gap = 0;
		no_idle = 1'b0;
		hold_requests = 0;
		hold_left = 0;
		load_count = 0;
		peak_q = '0;
		mode_q = MODE_PASS;
		cutoff_q = 23'd16384;
		slope_q = 23'd44564;
		intercept_q = 24'sd13107;
		default_q = 24'sd32768;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_MODE;
		cfg_data = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings, pass-through with field extremes and missing values
		push_beat(24'h7FFFFF, 1'b0);
		push_beat(24'h800000, 1'b0);
		push_beat(24'hFFFFFF, 1'b0);
		push_beat(24'd0, 1'b1);
		drain();

		// piecewise at every breakpoint and the peak, just above two of them, and a missing value
		write_reg(REG_MODE, {21'd0, MODE_PIECE});
		push_beat(24'd0, 1'b0);
		push_beat(24'd16384, 1'b0);
		push_beat(24'd16385, 1'b0);
		push_beat(24'd19661, 1'b0);
		push_beat(24'd45875, 1'b0);
		push_beat(24'd45876, 1'b0);
		push_beat(24'hFFF000, 1'b0);
		push_beat(24'd70000, 1'b1);
		drain();

		// cutoff right at the threshold, log of zero and of one
		set_all(MODE_CUT, 23'd0, 23'd1, 24'h800000, 24'h7FFFFF);
		push_beat(24'd0, 1'b0);
		push_beat(24'hFFFFFF, 1'b1);
		drain();
		set_all(MODE_LOG, 23'h7FFFFF, 23'h7FFFFF, 24'h7FFFFF, 24'h800000);
		push_beat(24'd0, 1'b0);
		push_beat(24'd65536, 1'b0);
		push_beat(24'h800000, 1'b1);
		drain();
		set_all(MODE_LOG, 23'd16384, 23'd44564, 24'hFED600, 24'd0);
		push_beat(24'd0, 1'b0);
		push_beat(24'd1, 1'b0);
		push_beat(24'd65536, 1'b0);
		push_beat(24'h7FFFFF, 1'b1);
		drain();

		// zero slope, undefined modes and writes to unused register slots
		set_all(MODE_LIN, 23'd16384, 23'd0, 24'd13107, 24'd32768);
		push_beat(24'd13107, 1'b0);
		push_beat(24'd13108, 1'b1);
		drain();
		write_reg(REG_MODE, {21'd0, MODE_UNDEF_LO});
		write_reg(REG_UNUSED_LO, 24'hFFFFFF);
		write_reg(REG_UNUSED_HI, 24'h000001);
		push_beat(24'hFFFFFF, 1'b0);
		push_beat(24'd1234, 1'b1);
		drain();

		// full store closes the profile without the marker
		write_reg(REG_MODE, {21'd0, MODE_UNDEF_HI});
		for (int i = 0; i < PROFILE_MAX; i++)
			push_beat(pick_reactivity(), 1'b0);
		drain();

		// random phases; one holds off the receiver while a full profile and more queue up
		for (int ph = 0; ph < 12; ph++) begin
			set_all(($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4)),
				pick_level(),
				($urandom_range(0, 29) == 0) ? 23'd0 :
					(($urandom_range(0, 3) == 0) ? 23'($urandom_range(1, 8388607)) :
					23'($urandom_range(1, 140000))),
				($urandom_range(0, 3) == 0) ? 24'($urandom()) :
					24'($signed($urandom_range(0, 200000)) - 100000),
				($urandom_range(0, 2) == 0) ? 24'($urandom()) : 24'($urandom_range(0, 80000)));
			if (ph == 3) begin
				hold_requests++;
				for (int i = 0; i < PROFILE_MAX; i++)
					push_beat(pick_reactivity(), 1'b0);
			end
			queue_profiles(18);
			drain();
		end

		if (errors == 0 && expected_results.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
